### sv/midi_port_rx_fifo_registers_macros.svh
// Assertion macros shared by the MIDI port receive FIFO register block.
`ifndef MIDI_PORT_RX_FIFO_REGISTERS_MACROS_SVH
`define MIDI_PORT_RX_FIFO_REGISTERS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MPRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MPRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mprx_pkg.sv
// Package with the constants and types of the MIDI port receive FIFO register block.
`timescale 1ns / 1ps

package mprx_pkg;

    // Receive FIFO geometry.
    localparam int FIFO_DEPTH = 2048;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Transaction kinds carried on the input tuser.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    // Register offsets within the port.
    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_CTRL   = 3'd1;
    localparam logic [2:0] REG_IRQ    = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd5;

    // Control byte bit positions.
    localparam int CTRL_RX_IRQ_BIT   = 0;
    localparam int CTRL_TX_IRQ_BIT   = 1;
    localparam int CTRL_LOOPBACK_BIT = 4;

    // Fixed read values.
    localparam logic [7:0] STATUS_BASE = 8'h20;
    localparam logic [7:0] READ_IDLE   = 8'hFF;

    // Request from the register logic to the FIFO.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } mprx_fifo_req_t;

    // Fill state reported by the FIFO.
    typedef struct packed {
        logic empty;
        logic full;
    } mprx_fifo_status_t;

endpackage

### sv/mprx_fifo.sv
// Receive FIFO of the MIDI port: byte memory, pointers, fill count and registered read data.
`timescale 1ns / 1ps
`include "midi_port_rx_fifo_registers_macros.svh"

module mprx_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mprx_pkg::mprx_fifo_req_t      req,
    output mprx_pkg::mprx_fifo_status_t   status,
    output logic [7:0]                    rd_data
);
    import mprx_pkg::*;

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Fill state flags.
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign rd_data      = rd_data_reg;

    // Pointer wrap and count update.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (req.push)
        begin
            wptr_next = (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (req.pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (req.push && !req.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (req.pop && !req.push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Byte memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[wptr_reg] <= req.wdata;
        end
        if (req.pop)
        begin
            rd_data_reg <= mem[rptr_reg];
        end
    end

    `MPRX_ASSERT_NOW(a_no_push_full, clk, rst_n, req.push, !status.full,
        "FIFO push while full")
    `MPRX_ASSERT_NOW(a_no_pop_empty, clk, rst_n, req.pop, !status.empty,
        "FIFO pop while empty")
    `MPRX_ASSERT_NEXT(a_count_up, clk, rst_n, req.push && !req.pop,
        cnt_reg == $past(cnt_reg) + 1'b1, "FIFO count did not follow a push")

endmodule

### sv/midi_port_rx_fifo_registers.sv
// Top level of the MIDI port register block with its receive FIFO.
`timescale 1ns / 1ps
`include "midi_port_rx_fifo_registers_macros.svh"

// The input stream carries one transaction per item: a bus read, a bus write
// or one received MIDI byte. s_tuser holds the kind, s_tdata the register
// offset and the data byte, and s_tlast marks the last byte of a message.
// Each accepted transaction yields exactly one result on the output stream:
// the read data, the byte sent to MIDI out (flagged on m_tuser), the level of
// the interrupt line after the transaction and a flag for a received byte that
// was dropped because the FIFO was full.
// From acceptance to m_tvalid a transaction passes through the input
// register, where the register and FIFO state are updated, and the result
// register; for a pop the FIFO read register holds the memory read data.
// Throughput is one transaction per cycle while the receiver does not stall;
// the limit is the single memory read port and the state update of each one.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and s_tready drops once both are occupied.
// Reset clears the control byte, the interrupt state and the FIFO pointers,
// leaving the FIFO empty; the memory contents are not cleared.
module midi_port_rx_fifo_registers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [2:0] addr, [10:3] data, [15:11] zero
    input  logic [1:0]  s_tuser,  // [1:0] op
    input  logic        s_tlast,  // msg_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [7:0] read_data, [15:8] midi_out_byte,
                                  // [16] irq_level, [17] rx_dropped, [23:18] zero
    output logic        m_tuser   // [0] midi_out_valid
);
    import mprx_pkg::*;

    // Input register stage.
    logic       s1_valid_reg;
    logic [1:0] in_op_reg;
    logic [2:0] in_addr_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // Port state.
    logic [7:0] ctrl_reg;
    logic [7:0] ctrl_next;
    logic       pend_reg;
    logic       pend_next;
    logic       line_reg;
    logic       line_next;

    // Result register stage.
    logic       out_valid_reg;
    logic [7:0] res_rd_reg;
    logic       res_pop_reg;
    logic       res_tx_valid_reg;
    logic [7:0] res_tx_byte_reg;
    logic       res_irq_reg;
    logic       res_drop_reg;

    // Per-transaction results.
    logic       s1_adv;
    logic       fire;
    logic [7:0] rd;
    logic       pop_sel;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       drop;
    logic       push;
    logic       pop;

    mprx_fifo_req_t    fifo_req;
    mprx_fifo_status_t fifo_status;
    logic [7:0]        fifo_rd_data;

    // Handshake: the input stage moves on whenever the result register is free.
    assign s1_adv   = !out_valid_reg || m_tready;
    assign fire     = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;

    // Register map decode and state update for the transaction in the input stage.
    always_comb
    begin
        rd        = '0;
        pop_sel   = 1'b0;
        tx_valid  = 1'b0;
        tx_byte   = '0;
        drop      = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        ctrl_next = ctrl_reg;
        pend_next = pend_reg;
        line_next = line_reg;
        case (in_op_reg)
            OP_READ:
            begin
                case (in_addr_reg)
                    REG_DATA:
                    begin
                        if (!fifo_status.empty)
                        begin
                            pop     = 1'b1;
                            pop_sel = 1'b1;
                        end
                    end
                    REG_CTRL:   rd = ctrl_reg;
                    REG_IRQ:    rd = {7'b0, pend_reg};
                    REG_STATUS: rd = STATUS_BASE | {7'b0, !fifo_status.empty};
                    default:    rd = READ_IDLE;
                endcase
            end
            OP_WRITE:
            begin
                case (in_addr_reg)
                    REG_DATA:
                    begin
                        if (ctrl_reg[CTRL_LOOPBACK_BIT])
                        begin
                            push = !fifo_status.full;
                            drop = fifo_status.full;
                            if (ctrl_reg[CTRL_RX_IRQ_BIT])
                            begin
                                pend_next = 1'b1;
                                line_next = 1'b1;
                            end
                        end
                        else
                        begin
                            tx_valid = 1'b1;
                            tx_byte  = in_data_reg;
                            if (ctrl_reg[CTRL_TX_IRQ_BIT])
                            begin
                                pend_next = 1'b1;
                                line_next = 1'b1;
                            end
                        end
                    end
                    REG_CTRL: ctrl_next = in_data_reg;
                    REG_IRQ:
                    begin
                        pend_next = pend_reg & ~in_data_reg[0];
                        line_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            OP_RX:
            begin
                push = !fifo_status.full;
                drop = fifo_status.full;
                if (in_last_reg && ctrl_reg[CTRL_RX_IRQ_BIT])
                begin
                    pend_next = 1'b1;
                    line_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // FIFO requests only take effect when the transaction leaves the input stage.
    assign fifo_req.push  = fire && push;
    assign fifo_req.pop   = fire && pop;
    assign fifo_req.wdata = in_data_reg;

    mprx_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fifo_req),
        .status  (fifo_status),
        .rd_data (fifo_rd_data)
    );

    // Control registers of both stages and the port state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            pend_reg      <= 1'b0;
            line_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                ctrl_reg <= ctrl_next;
                pend_reg <= pend_next;
                line_reg <= line_next;
            end
        end
    end

    // Payload of the input register.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_addr_reg <= s_tdata[2:0];
            in_data_reg <= s_tdata[10:3];
            in_last_reg <= s_tlast;
        end
    end

    // Payload of the result register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_rd_reg       <= rd;
            res_pop_reg      <= pop_sel;
            res_tx_valid_reg <= tx_valid;
            res_tx_byte_reg  <= tx_byte;
            res_irq_reg      <= line_next;
            res_drop_reg     <= drop;
        end
    end

    // Output packing; a pop takes its byte from the FIFO read register.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_tx_valid_reg;
    assign m_tdata  = {6'b0, res_drop_reg, res_irq_reg, res_tx_byte_reg,
                       res_pop_reg ? fifo_rd_data : res_rd_reg};

    `MPRX_ASSERT_NOW(a_line_implies_pending, clk, rst_n, line_reg, pend_reg,
        "Interrupt line high without a pending interrupt")
    `MPRX_ASSERT_NEXT(a_tx_flagged, clk, rst_n,
        fire && in_op_reg == OP_WRITE && in_addr_reg == REG_DATA && !ctrl_reg[CTRL_LOOPBACK_BIT],
        m_tvalid && m_tuser, "Data write without loopback did not reach MIDI out")
    `MPRX_ASSERT_NEXT(a_drop_flagged, clk, rst_n,
        fire && in_op_reg == OP_RX && fifo_status.full,
        m_tvalid && m_tdata[17], "Received byte lost on a full FIFO was not flagged")

endmodule

### tb/midi_port_rx_fifo_registers_tb.sv
// Self-checking testbench for the MIDI port register block with its receive FIFO.
`timescale 1ns / 1ps

module midi_port_rx_fifo_registers_tb;

    import mprx_pkg::*;

    // The spare transaction kind that the block must treat as a no-op.
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_TXNS = 400;

    // One bus read, bus write or received MIDI byte, as queued for the driver.
    typedef struct {
        logic [1:0] op;
        logic [2:0] addr;
        logic [7:0] data;
        logic       msg_end;
        bit         hold;
    } port_txn_t;

    // One result transaction of the block.
    typedef struct {
        logic [7:0] read_data;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       irq_level;
        logic       dropped;
    } port_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [2:0] addr, [10:3] data, [15:11] zero
    logic [1:0]  s_tuser = '0;   // [1:0] op
    logic        s_tlast = 1'b0; // msg_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [7:0] read_data, [15:8] midi_out_byte,
                                 // [16] irq_level, [17] rx_dropped, [23:18] zero
    logic        m_tuser;        // [0] midi_out_valid

    port_txn_t  txn_q[$];
    port_resp_t resp_expect_q[$];
    port_txn_t  drv_txn;
    port_resp_t drv_resp;
    port_resp_t mon_resp;
    int         err_count = 0;
    int         cycle_count = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    bit         send_calm = 1'b0;
    bit         recv_calm = 1'b0;

    // Predicted state of the port.
    logic [7:0] ctrl_reg;
    logic       pend_bit;
    logic       irq_ln;
    logic [7:0] rx_bytes[$];

    midi_port_rx_fifo_registers DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Draws a random wait; now and then switches to a run without waits.
    function automatic int pick_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Pushes a byte into the predicted FIFO; returns 1 when the FIFO is full.
    function automatic logic rx_push(input logic [7:0] b);
        if (rx_bytes.size() >= FIFO_DEPTH)
            return 1'b1;
        rx_bytes.push_back(b);
        return 1'b0;
    endfunction

    // Applies one transaction to the predicted state and works out its result.
    task automatic step_port_regs(input port_txn_t t, output port_resp_t r);
        r = '{read_data: 8'h00, out_valid: 1'b0, out_byte: 8'h00,
              irq_level: 1'b0, dropped: 1'b0};
        case (t.op)
            OP_READ:
            begin
                case (t.addr)
                    REG_DATA:   r.read_data = (rx_bytes.size() != 0) ? rx_bytes.pop_front() : 8'h00;
                    REG_CTRL:   r.read_data = ctrl_reg;
                    REG_IRQ:    r.read_data = {7'b0, pend_bit};
                    REG_STATUS: r.read_data = STATUS_BASE | {7'b0, rx_bytes.size() != 0};
                    default:    r.read_data = READ_IDLE;
                endcase
            end
            OP_WRITE:
            begin
                case (t.addr)
                    REG_DATA:
                    begin
                        if (ctrl_reg[CTRL_LOOPBACK_BIT])
                        begin
                            // Loopback behaves like a received byte that ends a message.
                            r.dropped = rx_push(t.data);
                            if (ctrl_reg[CTRL_RX_IRQ_BIT])
                            begin
                                pend_bit = 1'b1;
                                irq_ln   = 1'b1;
                            end
                        end
                        else
                        begin
                            r.out_valid = 1'b1;
                            r.out_byte  = t.data;
                            if (ctrl_reg[CTRL_TX_IRQ_BIT])
                            begin
                                pend_bit = 1'b1;
                                irq_ln   = 1'b1;
                            end
                        end
                    end
                    REG_CTRL: ctrl_reg = t.data;
                    REG_IRQ:
                    begin
                        pend_bit = pend_bit & ~t.data[0];
                        irq_ln   = 1'b0;
                    end
                    default: ;
                endcase
            end
            OP_RX:
            begin
                // A dropped byte still raises the receive interrupt.
                r.dropped = rx_push(t.data);
                if (t.msg_end && ctrl_reg[CTRL_RX_IRQ_BIT])
                begin
                    pend_bit = 1'b1;
                    irq_ln   = 1'b1;
                end
            end
            default: ;
        endcase
        r.irq_level = irq_ln;
    endtask

    task automatic queue_txn(input logic [1:0] op, input logic [2:0] addr,
                             input logic [7:0] data, input logic msg_end, input bit hold);
        port_txn_t t;
        t = '{op: op, addr: addr, data: data, msg_end: msg_end, hold: hold};
        txn_q.push_back(t);
    endtask

    // Random transaction, mostly register traffic and received bytes.
    task automatic queue_random_txn(input bit hold);
        int         pick;
        logic [2:0] addr;
        pick = $urandom_range(0, 99);
        addr = 3'($urandom_range(0, 7));
        if (pick < 30)
            queue_txn(OP_RX, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), hold);
        else if (pick < 62)
        begin
            if ($urandom_range(0, 2) == 0)
                addr = REG_DATA;
            else if ($urandom_range(0, 2) == 0)
                addr = REG_STATUS;
            queue_txn(OP_READ, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      hold);
        end
        else if (pick < 95)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                addr = REG_DATA;
            else if (pick < 6)
                addr = REG_CTRL;
            else if (pick < 8)
                addr = REG_IRQ;
            queue_txn(OP_WRITE, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      hold);
        end
        else
            queue_txn(OP_SPARE, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      hold);
    endtask

    // Build the stimulus, apply reset and wait for the end of the run.
    initial
    begin
        ctrl_reg = 8'h00;
        pend_bit = 1'b0;
        irq_ln   = 1'b0;

        // Register map and interrupt basics on an empty FIFO.
        queue_txn(OP_READ, REG_STATUS, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, 3'd3, 8'hFF, 1'b1, 1'b0);
        queue_txn(OP_READ, 3'd4, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, 3'd6, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, 3'd7, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_WRITE, REG_CTRL, 8'h03, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_CTRL, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_WRITE, REG_DATA, 8'hFF, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_IRQ, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_WRITE, REG_IRQ, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_WRITE, REG_IRQ, 8'h01, 1'b0, 1'b0);
        queue_txn(OP_RX, 3'd0, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_RX, 3'd7, 8'hFF, 1'b1, 1'b0);
        queue_txn(OP_WRITE, REG_IRQ, 8'hFF, 1'b1, 1'b0);
        // Loopback of a data write into the FIFO, then drain past empty.
        queue_txn(OP_WRITE, REG_CTRL, 8'h13, 1'b0, 1'b0);
        queue_txn(OP_WRITE, REG_DATA, 8'hA5, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_STATUS, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
        // Writes to unmapped offsets and the spare kind change nothing.
        queue_txn(OP_WRITE, 3'd7, 8'hFF, 1'b1, 1'b0);
        queue_txn(OP_WRITE, 3'd4, 8'h5A, 1'b0, 1'b0);
        queue_txn(OP_SPARE, 3'd7, 8'hFF, 1'b1, 1'b0);

        // Fill the FIFO past full with received and looped-back bytes, then drain it.
        queue_txn(OP_WRITE, REG_CTRL, 8'h11, 1'b0, 1'b1);
        for (int i = 0; i < FIFO_DEPTH + 6; i++)
        begin
            if (i % 256 == 100)
                queue_txn(OP_WRITE, REG_DATA, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else
                queue_txn(OP_RX, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0);
            if (i % 512 == 0)
                queue_txn(OP_READ, REG_STATUS, 8'h00, 1'b0, 1'b0);
        end
        queue_txn(OP_WRITE, REG_DATA, 8'h3C, 1'b0, 1'b0);
        queue_txn(OP_READ, REG_IRQ, 8'h00, 1'b0, 1'b0);
        queue_txn(OP_WRITE, REG_IRQ, 8'h01, 1'b0, 1'b0);
        for (int i = 0; i < FIFO_DEPTH + 2; i++)
        begin
            queue_txn(OP_READ, REG_DATA, 8'h00, 1'b0, 1'b0);
            if (i % 700 == 0)
                queue_txn(OP_READ, REG_STATUS, 8'h00, 1'b0, 1'b0);
        end
        queue_txn(OP_WRITE, REG_CTRL, 8'h00, 1'b0, 1'b0);

        // Random traffic; one point waits for every outstanding result first.
        for (int i = 0; i < RANDOM_TXNS; i++)
            queue_random_txn(i == RANDOM_TXNS / 2);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (txn_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (resp_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Driver: presents queued transactions and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                step_port_regs(drv_txn, drv_resp);
                resp_expect_q.push_back(drv_resp);
                send_gap = pick_wait(send_calm);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (txn_q.size() != 0 && !(txn_q[0].hold && resp_expect_q.size() != 0))
                begin
                    drv_txn = txn_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, drv_txn.data, drv_txn.addr};
                    s_tuser  <= drv_txn.op;
                    s_tlast  <= drv_txn.msg_end;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: takes results with random stalls and checks them in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (resp_expect_q.size() == 0)
                    report_mismatch("unexpected result transaction", m_tdata, 0);
                else
                begin
                    mon_resp = resp_expect_q.pop_front();
                    if (m_tdata[7:0] !== mon_resp.read_data)
                        report_mismatch("read_data", m_tdata[7:0], mon_resp.read_data);
                    if (m_tuser !== mon_resp.out_valid)
                        report_mismatch("midi_out_valid", m_tuser, mon_resp.out_valid);
                    if (m_tdata[15:8] !== mon_resp.out_byte)
                        report_mismatch("midi_out_byte", m_tdata[15:8], mon_resp.out_byte);
                    if (m_tdata[16] !== mon_resp.irq_level)
                        report_mismatch("irq_level", m_tdata[16], mon_resp.irq_level);
                    if (m_tdata[17] !== mon_resp.dropped)
                        report_mismatch("rx_dropped", m_tdata[17], mon_resp.dropped);
                end
                recv_stall = pick_wait(recv_calm);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
